>>> src/lbr_pkg.sv
package lbr_pkg;

	// Fixed field widths of the pixel stream.
	localparam int COORD_BITS = 12;
	localparam int COLOR_BITS = 24;
	localparam int ERR_BITS   = COORD_BITS + 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic        [COORD_BITS-1:0] dist_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic        [COLOR_BITS-1:0] color_t;

	// Item opcodes.
	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_STEP = 1'b1
	} action_t;

	typedef struct packed {
		action_t action;
		coord_t  start_x;
		coord_t  start_y;
		coord_t  end_x;
		coord_t  end_y;
		color_t  color;
	} in_item_t;

	typedef struct packed {
		coord_t pixel_x;
		coord_t pixel_y;
		color_t pixel_color;
		logic   last_pixel;
	} out_item_t;

	// Working description of the line being walked.
	typedef struct packed {
		logic   steep;
		coord_t major_pos;
		coord_t minor_pos;
		coord_t major_end;
		dist_t  major_delta;
		dist_t  minor_delta;
		logic   minor_down;
		err_t   doubled_error;
		color_t color;
	} line_t;

	// Control passed from the input stage to the walker.
	typedef struct packed {
		logic valid;
		logic load;
	} stage_ctrl_t;

endpackage

>>> src/bresenham_line_rasterizer.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    lbr_pkg::in_item_t (action, endpoints, colour)
// out      output     out_valid / out_ready  lbr_pkg::out_item_t (pixel, colour, last flag)
//
// An item is taken into the input register, and one pass of setup and step
// logic then writes the result register: one item per clock while the output
// is not stalled. The line state loops through that one stage, so pixels follow
// each other with no gap while steps come and out is ready. Reset clears
// the valid flags and leaves the block idle. A stalled output holds the input
// stage; a step while idle retires without a result even under a stall.
module bresenham_line_rasterizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lbr_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output lbr_pkg::out_item_t out_item
);
	import lbr_pkg::*;

	logic        s1_valid_q;
	in_item_t    item_s1;
	stage_ctrl_t ctrl;
	line_t       setup;
	logic        take;

	assign in_ready = !s1_valid_q || take;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_comb begin
		ctrl.valid = s1_valid_q;
		ctrl.load  = item_s1.action == ACT_LOAD;
	end

	lbr_setup u_setup (
		.item (item_s1),
		.line (setup)
	);

	lbr_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.setup     (setup),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

>>> src/lbr_setup.sv
module lbr_setup (
	input  lbr_pkg::in_item_t item,
	output lbr_pkg::line_t    line
);
	import lbr_pkg::*;

	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic signed [COORD_BITS:0] dmaj;
	logic signed [COORD_BITS:0] dmin;
	dist_t  adx;
	dist_t  ady;
	logic   steep;
	coord_t ma0;
	coord_t mn0;
	coord_t mb0;
	coord_t mnb0;
	coord_t ma;
	coord_t mna;
	coord_t mb;
	coord_t mnb;

	// Absolute endpoint differences decide which axis is the major one.
	always_comb begin
		dx = {item.end_x[COORD_BITS-1], item.end_x} - {item.start_x[COORD_BITS-1], item.start_x};
		dy = {item.end_y[COORD_BITS-1], item.end_y} - {item.start_y[COORD_BITS-1], item.start_y};
		adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
		ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
		steep = ady > adx;
	end

	// Swap axes for steep lines, then order the endpoints along the major axis.
	always_comb begin
		ma0  = steep ? item.start_y : item.start_x;
		mn0  = steep ? item.start_x : item.start_y;
		mb0  = steep ? item.end_y   : item.end_x;
		mnb0 = steep ? item.end_x   : item.end_y;
		if (ma0 > mb0) begin
			ma  = mb0;
			mna = mnb0;
			mb  = ma0;
			mnb = mn0;
		end else begin
			ma  = ma0;
			mna = mn0;
			mb  = mb0;
			mnb = mnb0;
		end
	end

	// Deltas and the starting error term, which is the major delta itself.
	always_comb begin
		dmaj = {mb[COORD_BITS-1], mb} - {ma[COORD_BITS-1], ma};
		dmin = {mnb[COORD_BITS-1], mnb} - {mna[COORD_BITS-1], mna};
		line.steep         = steep;
		line.major_pos     = ma;
		line.minor_pos     = mna;
		line.major_end     = mb;
		line.major_delta   = COORD_BITS'(dmaj);
		line.minor_delta   = dmin[COORD_BITS] ? COORD_BITS'(-dmin) : COORD_BITS'(dmin);
		line.minor_down    = !(mna < mnb);
		line.doubled_error = $signed({2'b00, COORD_BITS'(dmaj)});
		line.color         = item.color;
	end

endmodule

>>> src/lbr_walk.sv
module lbr_walk (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lbr_pkg::stage_ctrl_t ctrl,
	input  lbr_pkg::line_t       setup,
	output logic                 take,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lbr_pkg::out_item_t   out_item
);
	import lbr_pkg::*;

	localparam int WIDE_BITS = ERR_BITS + 1;

	logic      active_q;
	logic      out_valid_q;
	line_t     line_q;
	out_item_t out_item_q;

	line_t     cur;
	line_t     nxt;
	out_item_t pix;
	logic      last;
	logic      wants_out;
	logic      fire;
	logic signed [WIDE_BITS-1:0] e1;
	logic signed [WIDE_BITS-1:0] e2;

	// A load works from the fresh setup, a step from the held line.
	always_comb begin
		cur = ctrl.load ? setup : line_q;
		last = cur.major_pos == cur.major_end;
		pix.pixel_x     = cur.steep ? cur.minor_pos : cur.major_pos;
		pix.pixel_y     = cur.steep ? cur.major_pos : cur.minor_pos;
		pix.pixel_color = cur.color;
		pix.last_pixel  = last;
	end

	// One Bresenham step: subtract twice the minor delta, and on a negative
	// error move the minor coordinate and add back twice the major delta.
	always_comb begin
		e1 = WIDE_BITS'(cur.doubled_error) - $signed({2'b00, cur.minor_delta, 1'b0});
		e2 = e1 + $signed({2'b00, cur.major_delta, 1'b0});
		nxt = cur;
		nxt.major_pos = cur.major_pos + COORD_BITS'(1);
		if (e1 < 0) begin
			nxt.minor_pos = cur.minor_down ? cur.minor_pos - COORD_BITS'(1)
			                               : cur.minor_pos + COORD_BITS'(1);
			nxt.doubled_error = ERR_BITS'(e2);
		end else begin
			nxt.doubled_error = ERR_BITS'(e1);
		end
	end

	// A step while idle retires at once; anything else needs room at the output.
	always_comb begin
		wants_out = ctrl.load || active_q;
		take = ctrl.valid && (!wants_out || !out_valid_q || out_ready);
		fire = take && wants_out;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				active_q    <= !last;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Line state and result register.
	always_ff @(posedge clk) begin
		if (fire) begin
			line_q     <= nxt;
			out_item_q <= pix;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

>>> verif/tb_bresenham_line_rasterizer.sv
module tb_bresenham_line_rasterizer;
	timeunit 1ns;
	timeprecision 1ps;

	import lbr_pkg::*;

	localparam int RESET_CYCLES    = 8;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 8;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	// Predicted walker state, updated at each accepted input transfer.
	logic   walk_active      = 1'b0;
	logic   walk_steep       = 1'b0;
	coord_t walk_major       = '0;
	coord_t walk_minor       = '0;
	coord_t walk_major_end   = '0;
	dist_t  walk_major_delta = '0;
	dist_t  walk_minor_delta = '0;
	logic   walk_down        = 1'b0;
	err_t   walk_error       = '0;
	color_t walk_color       = '0;

	out_item_t pixel_queue[$];
	int        pixel_count      = 0;
	int        error_count      = 0;
	logic      no_idle          = 1'b0;
	logic      hold_off_request = 1'b0;

	bresenham_line_rasterizer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// Free-running 100 MHz clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Idle stretch length: mostly none or short, occasionally long.
	function automatic int idle_cycles();
		int r;
		if (no_idle) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Any coordinate of the full signed range.
	function automatic int rand_coord();
		return int'($urandom_range(0, 4095)) - 2048;
	endfunction

	// Emits the pixel at the current walker position, then advances it or, at the last pixel, ends the walk.
	function automatic void emit_pixel();
		out_item_t px;
		int        err;
		px.pixel_x     = walk_steep ? walk_minor : walk_major;
		px.pixel_y     = walk_steep ? walk_major : walk_minor;
		px.pixel_color = walk_color;
		px.last_pixel  = (walk_major == walk_major_end);
		pixel_queue.push_back(px);
		pixel_count++;
		if (px.last_pixel) begin
			walk_active = 1'b0;
		end else begin
			err = int'(walk_error) - 2 * int'(walk_minor_delta);
			if (err < 0) begin
				walk_minor = walk_down ? walk_minor - coord_t'(1) : walk_minor + coord_t'(1);
				err += 2 * int'(walk_major_delta);
			end
			walk_error = err_t'(err);
			walk_major = walk_major + coord_t'(1);
		end
	endfunction

	// Works out the pixel, if any, that one accepted item causes.
	function automatic void rasterize_item(in_item_t it);
		int ax, ay, bx, by, dx, dy, t;
		if (it.action == ACT_LOAD) begin
			ax = int'(it.start_x);
			ay = int'(it.start_y);
			bx = int'(it.end_x);
			by = int'(it.end_y);
			dx = (bx > ax) ? bx - ax : ax - bx;
			dy = (by > ay) ? by - ay : ay - by;
			walk_steep = (dy > dx);
			// Steep lines walk along y, so the axes trade places.
			if (walk_steep) begin
				t = ax; ax = ay; ay = t;
				t = bx; bx = by; by = t;
			end
			// The major coordinate always increases along the walk.
			if (ax > bx) begin
				t = ax; ax = bx; bx = t;
				t = ay; ay = by; by = t;
			end
			walk_major       = coord_t'(ax);
			walk_minor       = coord_t'(ay);
			walk_major_end   = coord_t'(bx);
			walk_major_delta = dist_t'(bx - ax);
			walk_minor_delta = dist_t'((by >= ay) ? by - ay : ay - by);
			walk_down        = !(ay < by);
			walk_error       = err_t'(bx - ax);
			walk_color       = it.color;
			walk_active      = 1'b1;
			emit_pixel();
		end else if (walk_active) begin
			emit_pixel();
		end
	endfunction

	function automatic in_item_t make_load(int sx, int sy, int ex, int ey, color_t c);
		in_item_t it;
		it.action  = ACT_LOAD;
		it.start_x = coord_t'(sx);
		it.start_y = coord_t'(sy);
		it.end_x   = coord_t'(ex);
		it.end_y   = coord_t'(ey);
		it.color   = c;
		return it;
	endfunction

	// Step item; the payload is ignored by the block, so it carries random bits.
	function automatic in_item_t make_step();
		in_item_t it;
		it.action  = ACT_STEP;
		it.start_x = coord_t'($urandom);
		it.start_y = coord_t'($urandom);
		it.end_x   = coord_t'($urandom);
		it.end_y   = coord_t'($urandom);
		it.color   = color_t'($urandom);
		return it;
	endfunction

	// Offers one item after a random gap and waits for its transfer.
	task automatic send_item(in_item_t item);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= item;
		do begin
			@(posedge clk);
		end while (!in_ready);
		rasterize_item(item);
	endtask

	task automatic walk_to_end();
		while (walk_active) begin
			send_item(make_step());
		end
	endtask

	// Extremes of the coordinate range and special cases of the walk.
	task automatic test_directed_lines();
		send_item(make_step());
		send_item(make_load(2047, 2047, 2047, 2047, 24'hFFFFFF));
		send_item(make_load(-2048, -2048, -2048, -2048, 24'h000000));
		send_item(make_step());
		send_item(make_load(3, 7, -3, 7, 24'h123456));
		walk_to_end();
		send_item(make_step());
		send_item(make_load(0, 0, 3, -3, 24'hA5C30F));
		walk_to_end();
		send_item(make_load(1, -2, 0, 2, 24'h5A3CF0));
		walk_to_end();
		// Full-span lines, each dropped part way by the next load.
		send_item(make_load(-2048, -2048, 2047, 2047, 24'hAAAAAA));
		send_item(make_step());
		send_item(make_step());
		send_item(make_load(2047, -2048, -2048, 2047, 24'h555555));
		send_item(make_step());
		send_item(make_load(-5, 2047, -6, -2048, 24'hF0F0F0));
		send_item(make_step());
	endtask

	// Mostly short lines walked to their end, with some large lines, early
	// reloads, steps while idle and random noise mixed in.
	task automatic test_random_lines(int pixel_goal);
		int       target;
		int       r;
		int       bx;
		int       by;
		in_item_t it;
		target = pixel_count + pixel_goal;
		while (pixel_count < target) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				bx = int'($urandom_range(0, 4000)) - 2000;
				by = int'($urandom_range(0, 4000)) - 2000;
				send_item(make_load(bx, by, bx + int'($urandom_range(0, 24)) - 12,
					by + int'($urandom_range(0, 24)) - 12, color_t'($urandom)));
				while (walk_active && $urandom_range(0, 99) >= 3) begin
					send_item(make_step());
				end
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 2)) send_item(make_step());
				end
			end else if (r < 90) begin
				send_item(make_load(rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), color_t'($urandom)));
				repeat ($urandom_range(0, 20)) send_item(make_step());
			end else begin
				it = make_step();
				if ($urandom_range(0, 1) == 1) begin
					it.action = ACT_LOAD;
				end
				send_item(it);
			end
		end
	endtask

	// The pixel sink holds off for a long stretch while steps keep coming,
	// so the block fills up and stalls its input.
	task automatic test_output_hold_off();
		send_item(make_load(-40, 20, 40, -30, color_t'($urandom)));
		hold_off_request = 1'b1;
		repeat (40) send_item(make_step());
		walk_to_end();
	endtask

	// Back-to-back transfers on both sides.
	task automatic test_back_to_back();
		no_idle = 1'b1;
		send_item(make_load(100, -200, 60, -190, color_t'($urandom)));
		walk_to_end();
		send_item(make_step());
		send_item(make_load(-7, 9, -7, 9, color_t'($urandom)));
		send_item(make_load(12, 30, 17, 2, color_t'($urandom)));
		walk_to_end();
		no_idle = 1'b0;
	endtask

	// Pixel sink: bursts of ready with random gaps, and one long hold-off
	// on request.
	initial begin : pixel_sink
		int burst;
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			burst = $urandom_range(1, 12);
			out_ready <= 1'b1;
			repeat (burst) @(posedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				gap = HOLD_OFF_CYCLES;
			end else begin
				gap = idle_cycles();
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Each output transfer is compared with the oldest predicted pixel.
	always @(posedge clk) begin : pixel_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pixel_queue.size() == 0) begin
				$error("unexpected pixel: x=%0d y=%0d", out_item.pixel_x, out_item.pixel_y);
				error_count++;
			end else begin
				want = pixel_queue.pop_front();
				if (out_item.pixel_x !== want.pixel_x) begin
					$error("pixel_x: expected %0d, got %0d", want.pixel_x, out_item.pixel_x);
					error_count++;
				end
				if (out_item.pixel_y !== want.pixel_y) begin
					$error("pixel_y: expected %0d, got %0d", want.pixel_y, out_item.pixel_y);
					error_count++;
				end
				if (out_item.pixel_color !== want.pixel_color) begin
					$error("pixel_color: expected %06h, got %06h", want.pixel_color,
						out_item.pixel_color);
					error_count++;
				end
				if (out_item.last_pixel !== want.last_pixel) begin
					$error("last_pixel: expected %0b, got %0b", want.last_pixel,
						out_item.last_pixel);
					error_count++;
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	initial begin : watchdog
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin : test_sequence
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_item  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_lines();
		test_random_lines(1250);
		test_output_hold_off();
		test_back_to_back();
		in_valid <= 1'b0;
		while (pixel_queue.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> files.f
src/lbr_pkg.sv
src/lbr_setup.sv
src/lbr_walk.sv
src/bresenham_line_rasterizer.sv
verif/tb_bresenham_line_rasterizer.sv
